FILE: hw/rtl/grd_pkg.sv
// ----------------------------------------------------------------------------
// grd_pkg: shared types and constants of the glove report decoder
// Widths, reset threshold and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package grd_pkg;

  localparam int unsigned THRESH_W     = 22;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 22'd40000;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned NUM_SENSORS  = 8;
  localparam int unsigned COORD_W      = 10;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 88;
  localparam logic [2:0] LAST_WORD     = 3'd5;
  localparam logic [7:0] START_BYTE    = 8'd1;

  // controller -> datapath
  typedef struct packed {
    logic       decode;     // realign and unpack stored report
    logic       filt_clear; // clear near flag for a new sensor i
    logic       filt_step;  // test pair (i, j)
    logic       filt_drop;  // drop sensor i if no near partner found
    logic [2:0] i;
    logic [2:0] j;
  } grd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       valid_sample;
    logic [7:0] vis;
    logic       near;
  } grd_stat_t;

  function automatic logic [19:0] sq10(input logic signed [COORD_W-1:0] a,
                                       input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W-1:0] u;
    begin
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      u = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
      sq10 = u * u;
    end
  endfunction

endpackage

FILE: hw/rtl/grd_datapath.sv
// ----------------------------------------------------------------------------
// grd_datapath: report store, realignment, unpacking and pair distance unit
// One pair distance is computed and compared per filter step.
// ----------------------------------------------------------------------------
module grd_datapath
  import grd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 word_we,
  input  logic [2:0]           word_idx,
  input  logic [WORD_W-1:0]    word_in,
  input  logic [THRESH_W-1:0]  thresh,
  input  grd_cmd_t             cmd,
  output grd_stat_t            stat,
  output logic [29:0]          bends_o,
  output logic [3:0]           buttons_o,
  output logic [11:0]          slots_o,
  output logic [29:0]          coords_o [NUM_SENSORS]
);

  logic [WORD_W-1:0] words_r [6];
  logic [7:0]  carry_r [16];
  logic [7:0]  carry_nxt [16];
  logic [2:0]  slot_r [4];
  logic [2:0]  slot_nxt [4];
  logic [29:0] coord_r [NUM_SENSORS];
  logic [29:0] coord_nxt [NUM_SENSORS];
  logic [7:0]  vis_r, vis_nxt;
  logic        valid_r, near_r;
  logic [29:0] bends_r, bends_nxt;
  logic [3:0]  buttons_r;
  logic [7:0]  raw [24];
  logic [7:0]  d [24];
  logic [31:0] w [4];
  logic [3:0]  s;
  logic [29:0] ci, cj;
  logic [21:0] pair_dist;

  always_ff @(posedge clk) begin
    if (word_we && word_idx <= LAST_WORD) begin
      words_r[word_idx] <= word_in;
    end
  end

  always_comb begin
    for (int k = 0; k < 24; k++) begin
      raw[k] = words_r[k/4][8*(k%4) +: 8];
    end
    carry_nxt = carry_r;
    if (raw[16] == START_BYTE) begin
      for (int k = 0; k < 8; k++) d[k] = carry_r[k];
      for (int k = 0; k < 16; k++) d[k+8] = raw[k];
      for (int k = 0; k < 8; k++) carry_nxt[k] = raw[k+16];
    end else if (raw[8] == START_BYTE) begin
      for (int k = 0; k < 16; k++) d[k] = carry_r[k];
      for (int k = 0; k < 8; k++) d[k+16] = raw[k];
      for (int k = 0; k < 16; k++) carry_nxt[k] = raw[k+8];
    end else begin
      d = raw;
    end
    bends_nxt = {d[4][7:2], d[3][5:0], d[2][3:0], d[3][7:6],
                 d[1][1:0], d[2][7:4], d[1][7:2]};
    w[0] = {2'b0, d[7][3:0], d[8], d[9], d[10], d[11][7:6]};
    w[1] = {2'b0, d[11][5:0], d[12], d[13], d[14]};
    w[2] = {2'b0, d[15], d[16], d[17], d[18][7:2]};
    w[3] = {2'b0, d[18][1:0], d[19], d[20], d[21], d[22][7:4]};
    slot_nxt = slot_r;
    coord_nxt = coord_r;
    vis_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      s = (k % 2 == 1) ? d[5 + (k+1)/2][7:4] : d[5 + (k+1)/2][3:0];
      if (!s[3]) begin
        slot_nxt[k] = s[2:0];
        coord_nxt[s[2:0]] = w[k][29:0];
        vis_nxt[s[2:0]] = 1'b1;
      end
    end
  end

  // pair distance: three 10-bit squares summed, max 3*1023^2 fits 22 bits
  assign ci = coord_r[cmd.i];
  assign cj = coord_r[cmd.j];
  assign pair_dist = 22'(sq10(ci[9:0], cj[9:0])) + 22'(sq10(ci[19:10], cj[19:10]))
                   + 22'(sq10(ci[29:20], cj[29:20]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) carry_r[k] <= '0;
      for (int k = 0; k < 4; k++) slot_r[k] <= '0;
      for (int k = 0; k < NUM_SENSORS; k++) coord_r[k] <= '0;
      vis_r   <= '0;
      valid_r <= 1'b0;
      near_r  <= 1'b0;
    end else begin
      if (cmd.decode) begin
        carry_r <= carry_nxt;
        valid_r <= (d[0] == START_BYTE);
        if (d[0] == START_BYTE) begin
          slot_r    <= slot_nxt;
          coord_r   <= coord_nxt;
          vis_r     <= vis_nxt;
          bends_r   <= bends_nxt;
          buttons_r <= d[5][7:4];
        end
      end
      if (cmd.filt_clear) begin
        near_r <= 1'b0;
      end else if (cmd.filt_step && vis_r[cmd.j] && pair_dist < thresh) begin
        near_r <= 1'b1;
      end
      if (cmd.filt_drop && !near_r) begin
        vis_r[cmd.i] <= 1'b0;
      end
    end
  end

  assign stat.valid_sample = valid_r;
  assign stat.vis  = vis_r;
  assign stat.near = near_r;
  assign bends_o   = bends_r;
  assign buttons_o = buttons_r;
  assign slots_o   = {slot_r[3], slot_r[2], slot_r[1], slot_r[0]};
  assign coords_o  = coord_r;

endmodule

FILE: hw/rtl/grd_ctrl.sv
// ----------------------------------------------------------------------------
// grd_ctrl: sequencer for decode, pairwise filter and result emission
// Walks sensor i over partners j, one pair a cycle, then streams results.
// ----------------------------------------------------------------------------
module grd_ctrl
  import grd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [2:0] in_idx,
  input  grd_stat_t  stat,
  input  logic       out_ready,
  output logic       in_ready,
  output logic       out_valid,
  output logic       out_hdr,
  output logic [2:0] out_sel,
  output grd_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_NEXTI  = 6'b000100,
    S_PAIR   = 6'b001000,
    S_DROP   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt;
  logic [3:0] ocnt_r, ocnt_nxt;
  logic       ilast;

  assign ilast = (i_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    ocnt_nxt = ocnt_r;
    cmd = '0;
    cmd.i = i_r;
    cmd.j = j_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_idx == LAST_WORD) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        i_nxt = '0;
        ocnt_nxt = '0;
        state_nxt = S_NEXTI;
      end
      S_NEXTI: begin
        if (!stat.valid_sample) begin
          state_nxt = S_EMIT;
        end else if (stat.vis[i_r]) begin
          cmd.filt_clear = 1'b1;
          j_nxt = '0;
          state_nxt = S_PAIR;
        end else if (ilast) begin
          state_nxt = S_EMIT;
        end else begin
          i_nxt = i_r + 3'd1;
        end
      end
      S_PAIR: begin
        cmd.filt_step = (j_r != i_r);
        j_nxt = j_r + 3'd1;
        if (j_r == 3'd7) state_nxt = S_DROP;
      end
      S_DROP: begin
        cmd.filt_drop = 1'b1;
        if (ilast) begin
          state_nxt = S_EMIT;
        end else begin
          i_nxt = i_r + 3'd1;
          state_nxt = S_NEXTI;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ocnt_nxt = ocnt_r + 4'd1;
          if (!stat.valid_sample || ocnt_r == 4'd8) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_hdr = (ocnt_r == 4'd0);
  assign out_sel = 3'(ocnt_r - 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
      ocnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ocnt_r <= 4'd8) else $error("too many results");
  a_decode_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_idx == LAST_WORD) |=> state_r == S_DECODE)
    else $error("decode not started");

endmodule

FILE: hw/rtl/glove_report_decoder_top.sv
// ----------------------------------------------------------------------------
// glove_report_decoder_top: sensor-glove report decoder
// Controller plus datapath; streams one header and, for a valid report, eight sensor results.
// ----------------------------------------------------------------------------
// Words 0 to 4 are taken one per cycle while idle. Word 5 starts a decode: the
// report is realigned and unpacked, then the consistency filter tests one sensor
// pair per cycle on a single shared distance unit, and the results follow: 9
// results (or one header for an invalid report) at one per cycle while the
// output is ready.
// Input is held off while a report is being decoded, filtered or emitted.
module glove_report_decoder_top
  import grd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [THRESH_W-1:0]    cfg_wdata,  // distance_threshold_sq
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // report_word[31:0], word_index[34:32]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // sample_valid, bends, buttons,
                                             // slot_sensors, sensor_index,
                                             // x_upper, y_lower, y_upper,
                                             // sensor_visible
  output logic                   out_tlast,
  output logic                   out_tuser   // result_kind
);

  logic [THRESH_W-1:0] thresh_r;
  grd_cmd_t  cmd;
  grd_stat_t stat;
  logic in_fire, hdr;
  logic [2:0]  sel;
  logic [29:0] bends, c;
  logic [3:0]  buttons;
  logic [11:0] slots;
  logic [29:0] coords [NUM_SENSORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  assign in_fire = in_tvalid && in_tready;

  grd_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_idx(in_tdata[34:32]), .stat,
    .out_ready(out_tready), .in_ready(in_tready), .out_valid(out_tvalid),
    .out_hdr(hdr), .out_sel(sel), .cmd
  );

  grd_datapath u_dp (
    .clk, .rst_n, .word_we(in_fire), .word_idx(in_tdata[34:32]),
    .word_in(in_tdata[31:0]), .thresh(thresh_r), .cmd, .stat,
    .bends_o(bends), .buttons_o(buttons), .slots_o(slots), .coords_o(coords)
  );

  assign c = coords[sel];

  always_comb begin
    out_tdata = '0;
    out_tdata[0] = hdr ? stat.valid_sample : 1'b1;
    if (hdr) begin
      if (stat.valid_sample) begin
        out_tdata[30:1]  = bends;
        out_tdata[34:31] = buttons;
        out_tdata[46:35] = slots;
      end
    end else begin
      out_tdata[49:47] = sel;
      out_tdata[79:50] = c;
      out_tdata[80]    = stat.vis[sel];
    end
  end

  assign out_tlast = hdr ? !stat.valid_sample : (sel == 3'd7);
  assign out_tuser = !hdr;

endmodule

FILE: sim/glove_report_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// glove_report_decoder_top_tb: self-checking bench for the glove report decoder
// Streams six-word reports at offsets 0, 8 and 16 of a byte stream. Reports
// carry clustered and scattered sensor coordinates. An in-bench decoder with
// its own carry and sensor state predicts each header and sensor item. Every
// output item is checked field by field, under several distance thresholds.
// ----------------------------------------------------------------------------
module glove_report_decoder_top_tb;
  import grd_pkg::*;

  typedef logic [7:0] rep_t [24];

  typedef struct {
    logic        kind;
    logic        last;
    logic        sample_valid;
    logic [29:0] bends;
    logic [3:0]  buttons;
    logic [11:0] slots;
    logic [2:0]  sensor;
    logic [9:0]  x_upper;
    logic [9:0]  y_lower;
    logic [9:0]  y_upper;
    logic        visible;
  } glove_item_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [THRESH_W-1:0]    cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  glove_report_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // decoder state mirrored by the bench
  logic [31:0]         word_store [6];
  logic [7:0]          carry [16];
  logic [2:0]          slot_store [4];
  logic [29:0]         coords [8];
  logic [THRESH_W-1:0] thresh;

  logic [IN_TDATA_W-1:0] word_queue [$];
  glove_item_t           expected_items [$];
  logic [7:0]            byte_stream [$];

  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  int  hold_cnt;
  int  errors;
  int  stall_cycles;
  int  reports_decoded;
  int  valid_reports;
  int  items_checked;
  int  visible_seen;

  localparam int STALL_LIMIT = 20000;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int sq(input logic [9:0] a, input logic [9:0] b);
    int d;
    d = $signed(a) - $signed(b);
    return d * d;
  endfunction

  // apply one accepted word to the mirrored state; word 5 yields results
  task automatic decode_word(input logic [IN_TDATA_W-1:0] w);
    logic [2:0]  idx;
    logic [7:0]  raw [24];
    logic [7:0]  d [24];
    logic [29:0] fld [4];
    logic [7:0]  b;
    logic [3:0]  s;
    bit          vis [8];
    bit          near;
    glove_item_t r;
    idx = w[34:32];
    if (idx > LAST_WORD) return;
    word_store[idx] = w[31:0];
    if (idx != LAST_WORD) return;
    reports_decoded++;
    for (int i = 0; i < 24; i++) raw[i] = word_store[i / 4][8 * (i % 4) +: 8];
    if (raw[16] == START_BYTE) begin
      for (int i = 0; i < 8; i++) d[i] = carry[i];
      for (int i = 0; i < 16; i++) d[8 + i] = raw[i];
      for (int i = 0; i < 8; i++) carry[i] = raw[16 + i];
    end else if (raw[8] == START_BYTE) begin
      for (int i = 0; i < 16; i++) d[i] = carry[i];
      for (int i = 0; i < 8; i++) d[16 + i] = raw[i];
      for (int i = 0; i < 16; i++) carry[i] = raw[8 + i];
    end else begin
      d = raw;
    end
    r = '{default: '0};
    if (d[0] != START_BYTE) begin
      r.last = 1'b1;
      expected_items.push_back(r);
      return;
    end
    valid_reports++;
    fld[0] = {d[7][3:0], d[8], d[9], d[10], d[11][7:6]};
    fld[1] = {d[11][5:0], d[12], d[13], d[14]};
    fld[2] = {d[15], d[16], d[17], d[18][7:2]};
    fld[3] = {d[18][1:0], d[19], d[20], d[21], d[22][7:4]};
    vis = '{default: 0};
    for (int i = 0; i < 4; i++) begin
      b = d[5 + (i + 1) / 2];
      s = (i % 2) ? b[7:4] : b[3:0];
      if (s > 7) continue;
      slot_store[i] = s[2:0];
      coords[s[2:0]] = fld[i];
      vis[s[2:0]] = 1;
    end
    // drop isolated sensors in index order; earlier drops affect later tests
    for (int i = 0; i < 8; i++) begin
      if (!vis[i]) continue;
      near = 0;
      for (int j = 0; j < 8; j++) begin
        if (j == i || !vis[j]) continue;
        if (sq(coords[i][9:0], coords[j][9:0]) + sq(coords[i][19:10], coords[j][19:10]) +
            sq(coords[i][29:20], coords[j][29:20]) < int'(thresh))
          near = 1;
      end
      if (!near) vis[i] = 0;
    end
    r.sample_valid = 1'b1;
    r.bends = {d[4][7:2], d[3][5:0], d[2][3:0], d[3][7:6], d[1][1:0], d[2][7:4],
               d[1][7:2]};
    r.buttons = d[5][7:4];
    r.slots = {slot_store[3], slot_store[2], slot_store[1], slot_store[0]};
    expected_items.push_back(r);
    for (int i = 0; i < 8; i++) begin
      r = '{default: '0};
      r.kind = 1'b1;
      r.last = (i == 7);
      r.sample_valid = 1'b1;
      r.sensor = i[2:0];
      r.x_upper = coords[i][9:0];
      r.y_lower = coords[i][19:10];
      r.y_upper = coords[i][29:20];
      r.visible = vis[i];
      expected_items.push_back(r);
    end
  endtask

  // driver: advance to the next pending word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) decode_word(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_tdata  <= word_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor: random backpressure plus an occasional long hold
  always @(posedge clk) begin
    logic [87:0] od;
    glove_item_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        od = 88'(out_tdata);
        if (expected_items.size() == 0) begin
          $display("%0t: unexpected item, actual tdata %0h", $time, out_tdata);
          errors++;
        end else begin
          e = expected_items.pop_front();
          items_checked++;
          if (e.visible) visible_seen++;
          check_field("result_kind", e.kind, out_tuser);
          check_field("last", e.last, out_tlast);
          check_field("sample_valid", e.sample_valid, od[0]);
          check_field("bends", e.bends, od[30:1]);
          check_field("buttons", e.buttons, od[34:31]);
          check_field("slot_sensors", e.slots, od[46:35]);
          check_field("sensor_index", e.sensor, od[49:47]);
          check_field("x_upper", e.x_upper, od[59:50]);
          check_field("y_lower", e.y_lower, od[69:60]);
          check_field("y_upper", e.y_upper, od[79:70]);
          check_field("sensor_visible", e.visible, od[80]);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_cnt   <= 400;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("glove_report_decoder_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [9:0] pick_coord(input int center, input int spread);
    int v;
    if (spread < 0) return 10'($urandom);
    v = center + $urandom_range(2 * spread) - spread;
    if (v > 511) v = 511;
    if (v < -512) v = -512;
    return 10'(v);
  endfunction

  // build one logical report; spread < 0 scatters the coordinates
  task automatic make_report(output rep_t d, input bit ok, input int spread,
                             input int cx, input int cy, input int cz);
    logic [127:0] bits;
    logic [29:0]  fld [4];
    logic [3:0]   nib [4];
    for (int i = 0; i < 24; i++) d[i] = 8'($urandom);
    if (ok) d[0] = START_BYTE;
    else if (d[0] == START_BYTE) d[0] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      nib[i] = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
      fld[i] = {pick_coord(cz, spread), pick_coord(cy, spread), pick_coord(cx, spread)};
    end
    d[5] = {d[5][7:4], nib[0]};
    d[6] = {nib[1], nib[2]};
    bits = {nib[3], fld[0], fld[1], fld[2], fld[3], 4'($urandom)};
    for (int k = 0; k < 16; k++) d[7 + k] = bits[127 - 8 * k -: 8];
  endtask

  task automatic send_raw(input rep_t r);
    for (int k = 0; k < 6; k++) begin
      word_queue.push_back({5'd0, 3'(k), r[4 * k + 3], r[4 * k + 2], r[4 * k + 1], r[4 * k]});
      if ($urandom_range(15) == 0)
        word_queue.push_back({5'd0, 3'($urandom_range(7, 6)), 32'($urandom)});
    end
  endtask

  task automatic push_report(input rep_t r);
    rep_t c;
    for (int i = 0; i < 24; i++) byte_stream.push_back(r[i]);
    while (byte_stream.size() >= 24) begin
      for (int i = 0; i < 24; i++) c[i] = byte_stream.pop_front();
      send_raw(c);
    end
  endtask

  task automatic shift_stream(input int n);
    for (int i = 0; i < n; i++) byte_stream.push_back(8'($urandom_range(255, 2)));
  endtask

  task automatic wait_drained();
    @(posedge clk);
    #1;
    while (word_queue.size() > 0 || in_tvalid || expected_items.size() > 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic write_thresh(input logic [THRESH_W-1:0] v);
    wait_drained();
    // invalid reports leave no trailing item to wait on; allow the filter to finish
    repeat (90) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thresh = v;
  endtask

  task automatic random_reports(input int n);
    rep_t r;
    int   sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        shift_stream(8 * $urandom_range(2, 1));
      end else if (sel < 14) begin
        for (int i = 0; i < 24; i++) r[i] = 8'($urandom);
        send_raw(r);
        continue;
      end
      if (sel >= 14 && sel < 22) make_report(r, 0, -1, 0, 0, 0);
      else if (sel < 40) make_report(r, 1, -1, 0, 0, 0);
      else make_report(r, 1, $urandom_range(120, 5), $urandom_range(1023) - 512,
                       $urandom_range(1023) - 512, $urandom_range(1023) - 512);
      push_report(r);
    end
  endtask

  initial begin
    rep_t r;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    hold_req   = 0;
    send_idle  = 34;
    recv_idle  = 70;
    errors = 0;
    reports_decoded = 0;
    valid_reports = 0;
    items_checked = 0;
    visible_seen = 0;
    thresh = THRESH_RESET;
    carry = '{default: '0};
    slot_store = '{default: '0};
    coords = '{default: '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all-ones bends and buttons, coordinates at the top corner
    make_report(r, 1, 0, 511, 511, 511);
    r[1] = 8'hFF; r[2] = 8'hFF; r[3] = 8'hFF; r[4] = 8'hFF;
    r[5] = 8'hF0; r[6] = 8'h12;
    r[7] = {4'h3, r[7][3:0]};
    push_report(r);
    // bottom corner, with slots above 7 skipped
    make_report(r, 1, 0, -512, -512, -512);
    r[1] = 8'h00; r[2] = 8'h00; r[3] = 8'h00; r[4] = 8'h00;
    r[5] = 8'h0F; r[6] = 8'h9E;
    r[7] = {4'h4, r[7][3:0]};
    push_report(r);
    // invalid report, then an ignored word
    make_report(r, 0, -1, 0, 0, 0);
    push_report(r);
    word_queue.push_back({5'd0, 3'd7, 32'hFFFF_FFFF});
    write_thresh('0);
    make_report(r, 1, 0, 100, -100, 0);
    push_report(r);
    write_thresh(22'h3F_FFFF);

    // random reports mix scattered and clustered coordinates
    random_reports(5);
    hold_req = 1;
    @(posedge clk);
    #1;
    hold_req = 0;
    random_reports(4);
    wait_drained();
    random_reports(2);
    write_thresh(THRESH_RESET);

    send_idle = 70;
    recv_idle = 34;
    random_reports(6);
    write_thresh(22'($urandom_range(200000)));
    random_reports(2);

    send_idle = 0;
    recv_idle = 0;
    write_thresh(22'($urandom));
    random_reports(3);
    write_thresh(22'd1);
    random_reports(2);

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Decoded %0d reports (%0d valid), %0d output items checked, %0d visible.",
             reports_decoded, valid_reports, items_checked, visible_seen);
    $display("Covered stream offsets 0/8/16, slot skips, invalid starts, six thresholds.");
    if (errors == 0 && expected_items.size() == 0) begin
      $display("glove_report_decoder_top verification clean");
    end else begin
      $display("glove_report_decoder_top verification failed");
    end
    $finish;
  end

endmodule
